@@ rtl/core/cubic_spline_path_points_unit_assert.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef CUBIC_SPLINE_PATH_POINTS_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_PATH_POINTS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cspp_pkg.sv @@
`default_nettype none
package cspp_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int K_W          = $clog2(MAX_POINTS);
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int POS_W        = 32;
    localparam int HEAD_W       = 20;
    localparam int STEP_W       = 17;
    localparam int Z_W          = 35;
    localparam int XY_W         = 33;
    localparam int MAG_W        = 33;
    localparam int TAN_W        = 36;
    localparam int COEF_W       = 38;
    localparam int V_W          = 40;
    localparam int IN_W         = 168;
    localparam int OUT_W        = 88;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd3277;
    localparam logic [STEP_W:0]   T_ONE      = 18'd65536;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQUARE,
        OP_SQ_SUM,
        OP_SQRT,
        OP_TRIG_INIT,
        OP_CORDIC,
        OP_TRIG_SAVE,
        OP_TAN_MUL,
        OP_TAN_SAVE,
        OP_COEF,
        OP_PT_INIT,
        OP_PT_MUL,
        OP_PT_ADD,
        OP_PT_SAVE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
        logic       sel;
        logic       first;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic t_end;
    } sts_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:    r = 35'sd843314856;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043836;
            5'd3:    r = 35'sd133525158;
            5'd4:    r = 35'sd67021686;
            5'd5:    r = 35'sd33543515;
            5'd6:    r = 35'sd16775850;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194282;
            5'd9:    r = 35'sd2097149;
            5'd10:   r = 35'sd1048575;
            5'd11:   r = 35'sd524287;
            5'd12:   r = 35'sd262143;
            5'd13:   r = 35'sd131071;
            5'd14:   r = 35'sd65535;
            5'd15:   r = 35'sd32767;
            5'd16:   r = 35'sd16383;
            5'd17:   r = 35'sd8191;
            5'd18:   r = 35'sd4095;
            5'd19:   r = 35'sd2047;
            5'd20:   r = 35'sd1023;
            5'd21:   r = 35'sd511;
            5'd22:   r = 35'sd255;
            5'd23:   r = 35'sd127;
            5'd24:   r = 35'sd63;
            5'd25:   r = 35'sd31;
            5'd26:   r = 35'sd15;
            5'd27:   r = 35'sd7;
            5'd28:   r = 35'sd3;
            5'd29:   r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cspp_ctrl.sv @@
`default_nettype none
module cspp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire cspp_pkg::sts_t sts,
    output cspp_pkg::cmd_t     cmd
);
    import cspp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_SQRT,
        S_TINIT,
        S_CORDIC,
        S_TSAVE,
        S_TMUL,
        S_TANSAVE,
        S_COEF,
        S_PINIT,
        S_PMUL,
        S_PADD,
        S_PSAVE,
        S_EMIT
    } state_t;

    state_t         state_reg;
    logic [4:0]     i_reg;
    logic           sel_reg;
    logic [K_W-1:0] k_reg;
    logic           m_valid_reg;
    logic           emit_ok;
    logic           last_pt;

    assign emit_ok  = !m_valid_reg || m_tready;
    assign last_pt  = (k_reg == K_W'(MAX_POINTS - 1)) || sts.t_end;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        cmd       = '0;
        cmd.op    = OP_IDLE;
        cmd.idx   = i_reg;
        cmd.sel   = sel_reg;
        cmd.first = (k_reg == '0);
        cmd.last  = last_pt;
        case (state_reg)
            S_IDLE:    cmd.op = s_tvalid ? OP_LOAD : OP_IDLE;
            S_SQUARE:  cmd.op = OP_SQUARE;
            S_SUM:     cmd.op = OP_SQ_SUM;
            S_SQRT:    cmd.op = OP_SQRT;
            S_TINIT:   cmd.op = OP_TRIG_INIT;
            S_CORDIC:  cmd.op = OP_CORDIC;
            S_TSAVE:   cmd.op = OP_TRIG_SAVE;
            S_TMUL:    cmd.op = OP_TAN_MUL;
            S_TANSAVE: cmd.op = OP_TAN_SAVE;
            S_COEF:    cmd.op = OP_COEF;
            S_PINIT:   cmd.op = OP_PT_INIT;
            S_PMUL:    cmd.op = OP_PT_MUL;
            S_PADD:    cmd.op = OP_PT_ADD;
            S_PSAVE:   cmd.op = OP_PT_SAVE;
            S_EMIT:    cmd.op = emit_ok ? OP_EMIT : OP_IDLE;
            default:   cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            sel_reg     <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && emit_ok)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    i_reg     <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (i_reg == 5'(SQRT_STEPS - 1))
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= S_TINIT;
                    end
                    i_reg <= i_reg + 5'd1;
                end
                S_TINIT:
                begin
                    i_reg     <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (i_reg == 5'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_TSAVE;
                    end
                    i_reg <= i_reg + 5'd1;
                end
                S_TSAVE:
                begin
                    i_reg <= '0;
                    if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_TINIT;
                    end
                    else
                    begin
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL:
                begin
                    state_reg <= S_TANSAVE;
                end
                S_TANSAVE:
                begin
                    if (i_reg == 5'd3)
                    begin
                        state_reg <= S_COEF;
                    end
                    else
                    begin
                        state_reg <= S_TMUL;
                    end
                    i_reg <= i_reg + 5'd1;
                end
                S_COEF:
                begin
                    k_reg     <= '0;
                    sel_reg   <= 1'b0;
                    state_reg <= S_PINIT;
                end
                S_PINIT:
                begin
                    i_reg     <= 5'd1;
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    state_reg <= S_PADD;
                end
                S_PADD:
                begin
                    if (i_reg == 5'd3)
                    begin
                        state_reg <= S_PSAVE;
                    end
                    else
                    begin
                        state_reg <= S_PMUL;
                    end
                    i_reg <= i_reg + 5'd1;
                end
                S_PSAVE:
                begin
                    if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_PINIT;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        sel_reg <= 1'b0;
                        k_reg   <= k_reg + K_W'(1);
                        if (last_pt)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_PINIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cspp_dp.sv @@
`default_nettype none
module cspp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cspp_pkg::cmd_t                cmd,
    output cspp_pkg::sts_t                     sts,
    input  wire logic [cspp_pkg::STEP_W-1:0]   step,
    input  wire logic [cspp_pkg::IN_W-1:0]     in_data,
    output logic      [cspp_pkg::OUT_W-1:0]    out_data,
    output logic                               out_last
);
    import cspp_pkg::*;

    logic signed [POS_W-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic        [HEAD_W-1:0] sh_reg, eh_reg;
    logic                     half_reg;
    logic        [63:0]       sqa_reg, sqb_reg, n_reg, root_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic                     neg_reg;
    logic signed [XY_W-1:0]   trig_reg [4];
    logic signed [66:0]       tp_reg;
    logic signed [TAN_W-1:0]  tan_reg [4];
    logic signed [COEF_W-1:0] coef_reg [8];
    logic signed [V_W-1:0]    v_reg;
    logic signed [57:0]       hp_reg;
    logic        [STEP_W-1:0] t_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [POS_W-1:0]  ox_reg, oy_reg;
    logic        [HEAD_W-1:0] oh_reg;
    logic                     olast_reg;

    logic signed [32:0]       dx, dy;
    logic        [32:0]       ux, uy;
    logic                     half;
    logic        [31:0]       hx, hy;
    logic        [5:0]        bsh;
    logic        [63:0]       bitv, trial;
    logic        [HEAD_W-1:0] hsel;
    logic signed [Z_W-1:0]    z0, z1;
    logic signed [XY_W-1:0]   xs, ys;
    logic        [MAG_W-1:0]  mag;
    logic signed [66:0]       tp_next, tp_rnd;
    logic signed [COEF_W-1:0] sx38, sy38, ex38, ey38, t0, t1, t2, t3;
    logic signed [57:0]       hp_next, hp_rnd;
    logic signed [V_W-1:0]    coef_ext;
    logic signed [POS_W-1:0]  vsat;

    assign dx   = {ex_reg[31], ex_reg} - {sx_reg[31], sx_reg};
    assign dy   = {ey_reg[31], ey_reg} - {sy_reg[31], sy_reg};
    assign ux   = dx[32] ? 33'(-dx) : 33'(dx);
    assign uy   = dy[32] ? 33'(-dy) : 33'(dy);
    assign half = ux[32] | ux[31] | uy[32] | uy[31];
    assign hx   = half ? ux[32:1] : ux[31:0];
    assign hy   = half ? uy[32:1] : uy[31:0];

    assign bsh   = 6'd62 - {cmd.idx, 1'b0};
    assign bitv  = 64'd1 << bsh;
    assign trial = root_reg + bitv;
    assign mag   = half_reg ? {root_reg[31:0], 1'b0} : {1'b0, root_reg[31:0]};

    assign hsel = cmd.sel ? eh_reg : sh_reg;
    assign z0   = Z_W'($signed({hsel, 14'b0}));
    assign z1   = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 :
                  (z0 <= -PI_Q30) ? z0 + TWO_PI_Q30 : z0;
    assign xs   = x_reg >>> cmd.idx;
    assign ys   = y_reg >>> cmd.idx;

    assign tp_next = trig_reg[cmd.idx[1:0]] * $signed({1'b0, mag});
    assign tp_rnd  = tp_reg + 67'sd536870912;

    assign sx38 = COEF_W'(sx_reg);
    assign sy38 = COEF_W'(sy_reg);
    assign ex38 = COEF_W'(ex_reg);
    assign ey38 = COEF_W'(ey_reg);
    assign t0   = COEF_W'(tan_reg[0]);
    assign t1   = COEF_W'(tan_reg[1]);
    assign t2   = COEF_W'(tan_reg[2]);
    assign t3   = COEF_W'(tan_reg[3]);

    assign hp_next  = v_reg * $signed({1'b0, t_reg});
    assign hp_rnd   = hp_reg + 58'sd32768;
    assign coef_ext = V_W'(coef_reg[{cmd.sel, cmd.idx[1:0]}]);

    assign vsat = (v_reg > 40'sd2147483647) ? 32'sh7FFFFFFF :
                  (v_reg < -40'sd2147483648) ? 32'sh80000000 : v_reg[31:0];

    assign sts.t_end = ({1'b0, t_reg} + {1'b0, step}) > T_ONE;
    assign out_data  = {4'b0, oh_reg, oy_reg, ox_reg};
    assign out_last  = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            t_reg <= '0;
        end
        else if (cmd.op == OP_EMIT && !cmd.last)
        begin
            t_reg <= t_reg + step;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                sx_reg <= in_data[31:0];
                sy_reg <= in_data[63:32];
                sh_reg <= in_data[83:64];
                ex_reg <= in_data[115:84];
                ey_reg <= in_data[147:116];
                eh_reg <= in_data[167:148];
            end
            OP_SQUARE:
            begin
                half_reg <= half;
                sqa_reg  <= 64'(hx) * 64'(hx);
                sqb_reg  <= 64'(hy) * 64'(hy);
            end
            OP_SQ_SUM:
            begin
                n_reg    <= sqa_reg + sqb_reg;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_reg    <= n_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_TRIG_INIT:
            begin
                x_reg <= GAIN_Q30;
                y_reg <= '0;
                if (z1 > HALF_PI_Q30)
                begin
                    z_reg   <= z1 - PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (z1 < -HALF_PI_Q30)
                begin
                    z_reg   <= z1 + PI_Q30;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg   <= z1;
                    neg_reg <= 1'b0;
                end
            end
            OP_CORDIC:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_q30(cmd.idx);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_q30(cmd.idx);
                end
            end
            OP_TRIG_SAVE:
            begin
                trig_reg[{cmd.sel, 1'b0}] <= neg_reg ? -x_reg : x_reg;
                trig_reg[{cmd.sel, 1'b1}] <= neg_reg ? -y_reg : y_reg;
            end
            OP_TAN_MUL:
            begin
                tp_reg <= tp_next;
            end
            OP_TAN_SAVE:
            begin
                tan_reg[cmd.idx[1:0]] <= tp_rnd[65:30];
            end
            OP_COEF:
            begin
                coef_reg[0] <= (sx38 <<< 1) - (ex38 <<< 1) + t2 + t0;
                coef_reg[1] <= -(t0 <<< 1) - t2 - (sx38 <<< 1) - sx38 + (ex38 <<< 1) + ex38;
                coef_reg[2] <= t0;
                coef_reg[3] <= sx38;
                coef_reg[4] <= (sy38 <<< 1) - (ey38 <<< 1) + t3 + t1;
                coef_reg[5] <= -(t1 <<< 1) - t3 - (sy38 <<< 1) - sy38 + (ey38 <<< 1) + ey38;
                coef_reg[6] <= t1;
                coef_reg[7] <= sy38;
            end
            OP_PT_INIT:
            begin
                v_reg <= V_W'(coef_reg[{cmd.sel, 2'b00}]);
            end
            OP_PT_MUL:
            begin
                hp_reg <= hp_next;
            end
            OP_PT_ADD:
            begin
                v_reg <= hp_rnd[55:16] + coef_ext;
            end
            OP_PT_SAVE:
            begin
                if (cmd.sel)
                begin
                    py_reg <= vsat;
                end
                else
                begin
                    px_reg <= vsat;
                end
            end
            OP_EMIT:
            begin
                ox_reg    <= px_reg;
                oy_reg    <= py_reg;
                olast_reg <= cmd.last;
                if (cmd.last)
                begin
                    oh_reg <= eh_reg;
                end
                else if (cmd.first)
                begin
                    oh_reg <= sh_reg;
                end
                else
                begin
                    oh_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/cubic_spline_path_points_unit.sv @@
// Channel   Direction  Transfer contents
// s_axis    in         start and end pose, one per path
// m_axis    out        one curve point per transfer, tlast on the final point
// apb       in         step_size register at address 0
//
// Set-up per path is dominated by 32 square-root steps and two 30-step CORDIC
// runs. Each point is then computed by the single Horner multiplier used six
// times in turn. Reset clears the control state and loads step_size with 3277.
// A stalled output holds the next point in the sequencer until the present one
// is taken; the input is taken only when idle.
`default_nettype none
module cubic_spline_path_points_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_heading, end_x, end_y, end_heading
    input  wire logic [167:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x, point_y, point_heading, zero pad
    output logic [87:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cspp_pkg::*;

    `include "cubic_spline_path_points_unit_assert.svh"

    logic [STEP_W-1:0] step_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    sts_t              sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_wr)
        begin
            step_reg <= pwdata[STEP_W-1:0];
        end
    end

    cspp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cspp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .step     (step_reg),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

    `CSPP_ASSERT_NEXT(a_busy_after_load, s_tvalid && s_tready, !s_tready, "input taken twice")
    `CSPP_ASSERT_NEXT(a_emit_valid, cmd.op == OP_EMIT, m_tvalid, "emitted point not valid")
    `CSPP_ASSERT_NEXT(a_last_idle, cmd.op == OP_EMIT && cmd.last, s_tready, "no idle after last")
    `CSPP_ASSERT_NEXT(a_cfg_write, cfg_wr, step_reg == $past(pwdata[STEP_W-1:0]), "step lost")

endmodule
`default_nettype wire

@@ bench/cubic_spline_path_points_checker.sv @@
`timescale 1ns / 1ps
module cubic_spline_path_points_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           mismatches,
    output int           points_pending
);
    import cspp_pkg::*;

    localparam logic [2:0] ADDR_STEP_SIZE = 3'd0;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint GAIN_Q = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [19:0]        heading;
        logic               last;
    } point_t;

    point_t expected_points[$];
    logic [16:0] step_reg;

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    task automatic heading_trig(input longint raw, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit neg;
        z = raw * 16384;
        x = GAIN_Q;
        y = 0;
        neg = 0;
        z = ((z % TWO_PI_Q) + TWO_PI_Q) % TWO_PI_Q;
        if (z > PI_Q) z = z - TWO_PI_Q;
        if (z > HALF_PI_Q)
        begin
            z = z - PI_Q;
            neg = 1;
        end
        else if (z < -HALF_PI_Q)
        begin
            z = z + PI_Q;
            neg = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fl_shift(y, i);
                y = y + fl_shift(x, i);
                z = z - longint'(atan_q30(i[4:0]));
            end
            else
            begin
                nx = x + fl_shift(y, i);
                y = y - fl_shift(x, i);
                z = z + longint'(atan_q30(i[4:0]));
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic longint horner(longint a, longint b, longint c, longint d, longint t);
        longint v;
        v = rnd_shift(a * t, 16) + b;
        v = rnd_shift(v * t, 16) + c;
        v = rnd_shift(v * t, 16) + d;
        return v;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_path(input logic [167:0] d);
        longint p0x, p0y, p1x, p1y, h0, h1, dx, dy, mag;
        longint c0, s0, c1, s1, txi, txf, tyi, tyf, t;
        longint unsigned ax, ay;
        int n;
        point_t pt;
        p0x = longint'($signed(d[31:0]));
        p0y = longint'($signed(d[63:32]));
        h0 = longint'($signed(d[83:64]));
        p1x = longint'($signed(d[115:84]));
        p1y = longint'($signed(d[147:116]));
        h1 = longint'($signed(d[167:148]));
        dx = p1x - p0x;
        dy = p1y - p0y;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if ((ax >> 31) != 0 || (ay >> 31) != 0)
        begin
            ax = ax >> 1;
            ay = ay >> 1;
            mag = 2 * int_sqrt(ax * ax + ay * ay);
        end
        else
            mag = int_sqrt(ax * ax + ay * ay);
        heading_trig(h0, c0, s0);
        heading_trig(h1, c1, s1);
        txi = rnd_shift(c0 * mag, 30);
        txf = rnd_shift(c1 * mag, 30);
        tyi = rnd_shift(s0 * mag, 30);
        tyf = rnd_shift(s1 * mag, 30);
        if (step_reg == 0)
            n = MAX_POINTS;
        else
        begin
            n = 65536 / int'(step_reg) + 1;
            if (n > MAX_POINTS) n = MAX_POINTS;
        end
        for (int k = 0; k < n; k++)
        begin
            t = longint'(step_reg) * k;
            pt.px = clamp32(horner(2 * p0x - 2 * p1x + txf + txi,
                -2 * txi - txf - 3 * p0x + 3 * p1x, txi, p0x, t));
            pt.py = clamp32(horner(2 * p0y - 2 * p1y + tyf + tyi,
                -2 * tyi - tyf - 3 * p0y + 3 * p1y, tyi, p0y, t));
            pt.last = (k == n - 1);
            pt.heading = pt.last ? d[167:148] : (k == 0 ? d[83:64] : 20'd0);
            expected_points.insert(expected_points.size(), pt);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t e;
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            mismatches <= 0;
            points_pending <= 0;
            expected_points.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_STEP_SIZE)
                step_reg <= pwdata[16:0];
            if (s_tvalid && s_tready)
                predict_path(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected point x=%h y=%h",
                            m_tdata[31:0], m_tdata[63:32]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (m_tdata[31:0] !== e.px || m_tdata[63:32] !== e.py
                        || m_tdata[83:64] !== e.heading || m_tlast !== e.last
                        || m_tdata[87:84] !== 4'd0)
                    begin
                        if (mismatches < 10)
                            $display("exp x=%h y=%h h=%h l=%b, got x=%h y=%h h=%h l=%b",
                                e.px, e.py, e.heading, e.last, m_tdata[31:0],
                                m_tdata[63:32], m_tdata[83:64], m_tlast);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            points_pending <= expected_points.size();
        end
    end
endmodule

@@ bench/cubic_spline_path_points_unit_test.sv @@
`timescale 1ns / 1ps
module cubic_spline_path_points_unit_test;
    localparam logic [2:0] ADDR_STEP_SIZE = 3'd0;
    localparam int IDLE_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           mismatches;
    int           points_pending;
    int           idle_cycles;
    int           stall_mode;

    cubic_spline_path_points_unit dut (.*);

    cubic_spline_path_points_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("cubic_spline_path_points_unit_test NOT OK");
            $finish;
        end
    end

    // The receiver switches between free-running, light and heavy stalling.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_step(input logic [16:0] v);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_STEP_SIZE;
        pwdata <= {15'd0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_path(input logic [167:0] d);
        s_tdata <= d;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 2000000) - 1000000;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(0, 20000000) - 10000000;
        endcase
    endfunction

    function automatic logic [167:0] rand_path();
        return {20'($urandom()), rand_pos(), rand_pos(), 20'($urandom()),
            rand_pos(), rand_pos()};
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (points_pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        logic [16:0] steps [6];
        logic [19:0] headings [6];
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        stall_mode = 0;
        idle_cycles = 0;
        steps = '{17'd0, 17'd65536, 17'd1041, 17'd65537, 17'd131071, 17'd16384};
        headings = '{20'h00000, 20'h7FFFF, 20'h80000, 20'h1921F, 20'hE6DE1, 20'h3243F};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_path({20'h0, 32'd0, 32'd0, 20'h0, 32'd0, 32'd0});
        send_path({20'h7FFFF, 32'h80000000, 32'h80000000, 20'h80000,
            32'h7FFFFFFF, 32'h7FFFFFFF});
        send_path({20'h1921F, 32'h7FFFFFFF, 32'h00010000, 20'hE6DE1,
            32'h80000000, 32'hFFFF0000});
        for (int i = 0; i < 6; i++)
        begin
            drain();
            write_step(steps[i]);
            send_path({headings[i], rand_pos(), rand_pos(), headings[5 - i],
                rand_pos(), rand_pos()});
            send_path({headings[5 - i], 32'h7FFFFFFF, 32'h80000000, headings[i],
                32'h80000000, 32'h7FFFFFFF});
        end

        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0: write_step(17'd1041);
                1: write_step(17'd65536);
                2: write_step(17'd3277);
                default: write_step(17'($urandom_range(1041, 65536)));
            endcase
            for (int i = 0; i < 20; i++)
                send_path(rand_path());
        end
        drain();
        if (mismatches == 0)
            $display("cubic_spline_path_points_unit_test OK");
        else
            $display("cubic_spline_path_points_unit_test NOT OK");
        $finish;
    end
endmodule
